@@ rtl/core/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, token and status codes and types of the postfix calculator.
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int DATA_W            = 32;
   localparam int FUNC_W            = 3;
   localparam int NUMBER_W          = 31;
   localparam int STATUS_W          = 3;
   localparam int ITER_W            = $clog2(DATA_W);
   localparam int STACK_DEPTH_DEF   = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH    = 3'd0,
      FUNC_ADD     = 3'd1,
      FUNC_SUB     = 3'd2,
      FUNC_MUL     = 3'd3,
      FUNC_DIV     = 3'd4,
      FUNC_UNKNOWN = 3'd5,
      FUNC_FINISH  = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_UNDER     = 3'd1,
      ST_OVER      = 3'd2,
      ST_DIVZERO   = 3'd3,
      ST_FINAL     = 3'd4,
      ST_FINALERR  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2,
      ALU_DIV = 2'd3
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

endpackage

@@ rtl/core/psc_alu.sv @@
// ----------------------------------------------------------------------------
// psc_alu
// Serial arithmetic unit: add and subtract one bit per cycle, multiply by
// shift and add one multiplier bit per cycle, restoring divide one quotient
// bit per cycle. A load step, DATA_W run steps and a fix-up step.
// ----------------------------------------------------------------------------
module psc_alu
   import psc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  alu_ctrl_type             ctrl,
   input  logic signed [DATA_W-1:0] operand_a,
   input  logic signed [DATA_W-1:0] operand_b,
   output logic                     done,
   output logic        [DATA_W-1:0] result
);

   typedef enum logic [2:0] {
      A_IDLE = 3'b001,
      A_RUN  = 3'b010,
      A_FIX  = 3'b100
   } alu_state_type;

   alu_state_type       state_ff, state_in;
   alu_op_type          op_ff, op_in;
   logic [DATA_W-1:0]   x_ff, x_in;
   logic [DATA_W-1:0]   y_ff, y_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;
   logic                carry_ff, carry_in;
   logic                neg_ff, neg_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;

   logic [DATA_W-1:0]   mag_a, mag_b;
   logic                xb, sum_bit;
   logic [DATA_W:0]     rem_shift, rem_diff;
   logic                qbit;

   always_comb begin
      mag_a     = operand_a[DATA_W-1] ? (DATA_W'(0) - operand_a) : operand_a;
      mag_b     = operand_b[DATA_W-1] ? (DATA_W'(0) - operand_b) : operand_b;
      // subtract adds the inverted subtrahend with carry in set
      xb        = x_ff[0] ^ (op_ff == ALU_SUB);
      sum_bit   = y_ff[0] ^ xb ^ carry_ff;
      rem_shift = {acc_ff, y_ff[DATA_W-1]};
      rem_diff  = rem_shift - {1'b0, x_ff};
      qbit      = ~rem_diff[DATA_W];
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      carry_in = carry_ff;
      neg_in   = neg_ff;
      iter_in  = iter_ff;
      case (state_ff)
         A_IDLE: begin
            if (ctrl.start) begin
               state_in = A_RUN;
               op_in    = ctrl.op;
               iter_in  = '0;
               acc_in   = '0;
               carry_in = (ctrl.op == ALU_SUB);
               neg_in   = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
               if (ctrl.op == ALU_DIV) begin
                  x_in = mag_a;
                  y_in = mag_b;
               end else begin
                  x_in = operand_a;
                  y_in = operand_b;
               end
            end
         end
         A_RUN: begin
            iter_in = iter_ff + ITER_W'(1);
            case (op_ff)
               ALU_ADD, ALU_SUB: begin
                  acc_in   = {sum_bit, acc_ff[DATA_W-1:1]};
                  carry_in = (y_ff[0] & xb) | (y_ff[0] & carry_ff) | (xb & carry_ff);
                  x_in     = x_ff >> 1;
                  y_in     = y_ff >> 1;
               end
               ALU_MUL: begin
                  acc_in = acc_ff + (x_ff[0] ? y_ff : '0);
                  x_in   = x_ff >> 1;
                  y_in   = y_ff << 1;
               end
               default: begin
                  // quotient bits shift into y as dividend bits leave it
                  acc_in = qbit ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
                  y_in   = {y_ff[DATA_W-2:0], qbit};
               end
            endcase
            if (iter_ff == ITER_W'(DATA_W - 1)) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      acc_ff   <= acc_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
      iter_ff  <= iter_in;
   end

   assign done = (state_ff == A_FIX);

   always_comb begin
      if (op_ff == ALU_DIV) begin
         result = neg_ff ? (DATA_W'(0) - y_ff) : y_ff;
      end else begin
         result = acc_ff;
      end
   end

endmodule

@@ rtl/core/postfix_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// postfix_stack_calculator
// Postfix evaluator: one token in, one status and value out, on a stack of
// signed 32-bit values with a latched error.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries one token (func, number) per transfer; the
// rsp_ channel returns exactly one status/value per token, in order.
// One token is worked on at a time; req_stall is high from acceptance until
// its result has moved into the output register.
// Push, finish, unknown operator and error cases take two stack reads on
// the single memory read port, a decision state and an output load. Add,
// subtract, multiply and divide also go through the serial unit, one bit per
// cycle over 32 steps plus a load and a fix-up step, before the output load.
// Reset clears the stack count, the error latch and the output valid; stack
// contents are not cleared, and values read from unwritten entries go unused.
// While rsp_stall is high the result holds in the output register; a new
// token may be accepted and worked on, and waits for the register to free.
// ----------------------------------------------------------------------------
module postfix_stack_calculator
   import psc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic        [FUNC_W-1:0]   req_func,
   input  logic        [NUMBER_W-1:0] req_number,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic signed [DATA_W-1:0]   rsp_value
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_FETCH_A = 6'b000010,
      S_FETCH_B = 6'b000100,
      S_DECIDE  = 6'b001000,
      S_CALC    = 6'b010000,
      S_RESP    = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                err_ff, err_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [NUMBER_W-1:0] number_ff, number_in;
   logic [DATA_W-1:0]   a_ff, a_in;
   logic [DATA_W-1:0]   rd_ff;
   status_type          res_status_ff, res_status_in;
   logic [DATA_W-1:0]   res_value_ff, res_value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;

   logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic                wr_en;
   logic [DATA_W-1:0]   wr_data;
   logic [CNT_W-1:0]    cnt_m1, cnt_m2;
   logic [DATA_W-1:0]   top_val, push_val;

   alu_ctrl_type        alu_ctrl;
   logic                alu_done;
   logic [DATA_W-1:0]   alu_result;

   psc_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (alu_ctrl),
      .operand_a (a_ff),
      .operand_b (rd_ff),
      .done      (alu_done),
      .result    (alu_result)
   );

   always_comb begin
      cnt_m1   = cnt_ff - CNT_W'(1);
      cnt_m2   = cnt_ff - CNT_W'(2);
      top_val  = (cnt_ff != '0) ? a_ff : '0;
      push_val = {1'b0, number_ff};
      rd_addr  = (state_ff == S_FETCH_B) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      func_in       = func_ff;
      number_in     = number_ff;
      a_in          = a_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[ADDR_W-1:0];
      wr_data       = push_val;
      alu_ctrl      = '{start: 1'b0, op: ALU_ADD};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               number_in = req_number;
               state_in  = S_FETCH_A;
            end
         end
         S_FETCH_A: begin
            state_in = S_FETCH_B;
         end
         S_FETCH_B: begin
            // top entry arrives here, the one below it next cycle
            a_in     = rd_ff;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            res_status_in = ST_OK;
            res_value_in  = top_val;
            state_in      = S_RESP;
            if (func_ff == FUNC_FINISH) begin
               if (!err_ff && cnt_ff == CNT_W'(1)) begin
                  res_status_in = ST_FINAL;
               end else begin
                  res_status_in = ST_FINALERR;
                  res_value_in  = '0;
               end
               cnt_in = '0;
               err_in = 1'b0;
            end else if (err_ff) begin
               res_status_in = ST_OK;
            end else if (func_ff == FUNC_PUSH) begin
               if (cnt_ff == CNT_W'(STACK_DEPTH)) begin
                  res_status_in = ST_OVER;
                  err_in        = 1'b1;
               end else begin
                  wr_en        = 1'b1;
                  cnt_in       = cnt_ff + CNT_W'(1);
                  res_value_in = push_val;
               end
            end else if (cnt_ff < CNT_W'(2)) begin
               res_status_in = ST_UNDER;
               err_in        = 1'b1;
            end else begin
               case (func_ff)
                  FUNC_ADD: begin
                     alu_ctrl = '{start: 1'b1, op: ALU_ADD};
                     state_in = S_CALC;
                  end
                  FUNC_SUB: begin
                     alu_ctrl = '{start: 1'b1, op: ALU_SUB};
                     state_in = S_CALC;
                  end
                  FUNC_MUL: begin
                     alu_ctrl = '{start: 1'b1, op: ALU_MUL};
                     state_in = S_CALC;
                  end
                  FUNC_DIV: begin
                     if (a_ff == '0) begin
                        res_status_in = ST_DIVZERO;
                        err_in        = 1'b1;
                     end else begin
                        alu_ctrl = '{start: 1'b1, op: ALU_DIV};
                        state_in = S_CALC;
                     end
                  end
                  default: begin
                     // unknown operator only checks the depth
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_CALC: begin
            if (alu_done) begin
               wr_en         = 1'b1;
               wr_addr       = cnt_m2[ADDR_W-1:0];
               wr_data       = alu_result;
               cnt_in        = cnt_m1;
               res_status_in = ST_OK;
               res_value_in  = alu_result;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      number_ff     <= number_in;
      a_ff          <= a_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

endmodule
